// File: rtl/fpr_pkg.sv
// ----------------------------------------------------------------------------
// fpr_pkg
// Shared constants for the fixed-point requantizer: register map and the
// random generator coefficients.
// ----------------------------------------------------------------------------
package fpr_pkg;

  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned PT_W   = 5;

  // register indexes, byte address is 4 * index
  localparam logic [1:0] REG_SOURCE_POINT    = 2'd0;
  localparam logic [1:0] REG_TARGET_POINT    = 2'd1;
  localparam logic [1:0] REG_STOCHASTIC_MODE = 2'd2;
  localparam logic [1:0] REG_RANDOM_SEED     = 2'd3;

  localparam logic [31:0] SEED_RESET = 32'd1;
  localparam logic [31:0] LCG_MUL    = 32'd1664525;
  localparam logic [31:0] LCG_ADD    = 32'd1013904223;

endpackage

// File: rtl/fixed_point_requantizer.sv
// ----------------------------------------------------------------------------
// fixed_point_requantizer
// Re-expresses signed 32-bit fixed-point samples at a new binary point, with
// round-half-to-even or LCG-driven stochastic rounding on right shifts.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  in_     | input     | in_valid / in_ready  | in_sample[31:0], in_last
//  out_    | output    | out_valid / out_ready| out_result_value[31:0],
//          |           |                      | out_result_last
//  cfg     | input     | psel / penable       | paddr[3:0], pwdata, prdata
//
//  one item per cycle sustained while out_ready is high; an accepted item
//  passes the input register, then the result register, before out_valid
//  rises
//  the shifter/rounding adder sits between the input register and the result
//  register; the one-step LCG multiply feeds the generator register
//  rst_n is synchronous: both stages empty, registers to their reset values
//  a stalled out_ready holds the result; one more item is still taken into
//  the input register, then in_ready drops
// ----------------------------------------------------------------------------
module fixed_point_requantizer (
  input  logic                        clk,
  input  logic                        rst_n,
  // input item channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [31:0]          in_sample,
  input  logic                        in_last,
  // result item channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [31:0]          out_result_value,
  output logic                        out_result_last,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fpr_pkg::ADDR_W-1:0]  paddr,
  input  logic [fpr_pkg::DATA_W-1:0]  pwdata,
  output logic [fpr_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  // configuration registers
  logic [fpr_pkg::PT_W-1:0] src_pt_r;
  logic [fpr_pkg::PT_W-1:0] tgt_pt_r;
  logic                     stoch_r;
  logic [31:0]              seed_r;
  logic [31:0]              lcg_r;
  logic [31:0]              lcg_nxt;

  logic       cfg_wr;
  logic [1:0] cfg_idx;
  logic       cfg_wr_seed;

  // pipeline
  logic        s1_vld_r;
  logic [31:0] s1_sample_r;
  logic        s1_last_r;
  logic        s1_adv;
  logic        out_free;
  logic        in_acc;

  logic        out_vld_r;
  logic [31:0] out_val_r;
  logic        out_last_r;

  // datapath
  logic                     shl_sel;
  logic [fpr_pkg::PT_W-1:0] shl_amt;
  logic [fpr_pkg::PT_W-1:0] shr_amt;
  logic [5:0]               rnd_shift;
  logic [31:0]              rnd_val;
  logic [31:0]              half;
  logic [31:0]              frac_mask;
  logic [31:0]              add_val;
  logic [32:0]              sum33;
  logic [32:0]              shr33;
  logic [31:0]              shr_res;
  logic [31:0]              res_val;
  logic                     lcg_step;

  assign pready      = 1'b1;
  assign cfg_idx     = paddr[3:2];
  assign cfg_wr      = psel & penable & pwrite;
  assign cfg_wr_seed = cfg_wr && (cfg_idx == fpr_pkg::REG_RANDOM_SEED);

  always_comb begin
    case (cfg_idx)
      fpr_pkg::REG_SOURCE_POINT:    prdata = {27'd0, src_pt_r};
      fpr_pkg::REG_TARGET_POINT:    prdata = {27'd0, tgt_pt_r};
      fpr_pkg::REG_STOCHASTIC_MODE: prdata = {31'd0, stoch_r};
      fpr_pkg::REG_RANDOM_SEED:     prdata = seed_r;
      default:                      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_pt_r <= '0;
      tgt_pt_r <= '0;
      stoch_r  <= 1'b0;
      seed_r   <= fpr_pkg::SEED_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        fpr_pkg::REG_SOURCE_POINT:    src_pt_r <= pwdata[fpr_pkg::PT_W-1:0];
        fpr_pkg::REG_TARGET_POINT:    tgt_pt_r <= pwdata[fpr_pkg::PT_W-1:0];
        fpr_pkg::REG_STOCHASTIC_MODE: stoch_r  <= pwdata[0];
        fpr_pkg::REG_RANDOM_SEED:     seed_r   <= pwdata;
        default: ;
      endcase
    end
  end

  // handshake: result register frees when taken, input register drains into it
  assign out_free = !out_vld_r || out_ready;
  assign s1_adv   = s1_vld_r && out_free;
  assign in_ready = !s1_vld_r || out_free;
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_sample_r <= in_sample;
      s1_last_r   <= in_last;
    end
  end

  // shift direction and amounts, config must stay static while items are in flight (not enforced)
  assign shl_sel   = (tgt_pt_r >= src_pt_r);
  assign shl_amt   = tgt_pt_r - src_pt_r;
  assign shr_amt   = src_pt_r - tgt_pt_r;
  assign rnd_shift = 6'd32 - {1'b0, shr_amt};

  // top shr_amt bits of the generator
  assign rnd_val   = lcg_r >> rnd_shift;
  assign half      = 32'd1 << (shr_amt - 5'd1);
  assign frac_mask = (half << 1) - 32'd1;
  assign add_val   = stoch_r ? rnd_val : half;

  assign sum33   = {s1_sample_r[31], s1_sample_r} + {1'b0, add_val};
  assign shr33   = $unsigned($signed(sum33) >>> shr_amt);
  assign shr_res = shr33[31:0];

  always_comb begin
    if (shl_sel) begin
      res_val = s1_sample_r << shl_amt;
    end else if (!stoch_r && ((s1_sample_r & frac_mask) == half)) begin
      // exact tie: force even
      res_val = {shr_res[31:1], 1'b0};
    end else begin
      res_val = shr_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_val_r  <= res_val;
      out_last_r <= s1_last_r;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_result_value = out_val_r;
  assign out_result_last  = out_last_r;

  // generator advances only on stochastic right shifts, reseeds at block end
  assign lcg_step = s1_adv && !shl_sel && stoch_r;

  always_comb begin
    lcg_nxt = lcg_r;
    if (cfg_wr_seed) begin
      lcg_nxt = pwdata;
    end else if (s1_adv && s1_last_r) begin
      lcg_nxt = seed_r;
    end else if (lcg_step) begin
      lcg_nxt = lcg_r * fpr_pkg::LCG_MUL + fpr_pkg::LCG_ADD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcg_r <= fpr_pkg::SEED_RESET;
    end else begin
      lcg_r <= lcg_nxt;
    end
  end

  // checks
  a_lcg_step: assert property (@(posedge clk) disable iff (!rst_n)
    (lcg_step && !s1_last_r && !cfg_wr_seed) |=>
      (lcg_r == $past(lcg_r * fpr_pkg::LCG_MUL + fpr_pkg::LCG_ADD)))
    else $error("generator did not advance on stochastic item");

  a_lcg_reseed: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_last_r && !cfg_wr_seed) |=> (lcg_r == $past(seed_r)))
    else $error("generator not reseeded after block end");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_vld_r && out_vld_r && !out_ready))
    else $error("input stalled with room in the pipeline");

  a_out_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !$past(out_vld_r) && $past(rst_n)) |-> $past(s1_adv))
    else $error("result appeared without an item leaving the input stage");

endmodule
